>>> rtl/fwd_pkg.sv
// Shared types and constants of the frame window difference block.
package fwd_pkg;

  localparam int MAX_WIDTH_D  = 1024;
  localparam int MAX_HEIGHT_D = 1024;
  localparam int MAX_HALF_D   = 7;
  localparam int FRAC_BITS_D  = 8;

  localparam int PIX_W      = 8;
  localparam int DIFF_W     = 11;
  localparam int DIFF_MAX   = 3 * 255;
  localparam int TOTAL_W    = 38;
  localparam int DIM_CFG_W  = 11;
  localparam int SIDE_CFG_W = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [DIM_CFG_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [DIM_CFG_W-1:0]  HEIGHT_RST = 11'd480;
  localparam logic [SIDE_CFG_W-1:0] SIDE_RST   = 4'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_WINDOW_SIDE  = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TGT,
    S_COL_RD,
    S_COL_WAIT,
    S_WIN_SET,
    S_WIN_RD,
    S_WIN_WAIT,
    S_DIV,
    S_NEXT,
    S_OUT
  } fwd_state_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

>>> rtl/fwd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/fwd_div.sv
// Restoring divider, one quotient bit per cycle.
module fwd_div #(
  parameter int DVD_W = 26,
  parameter int DVS_W = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fwd_pkg::div_ctl_t      ctl_in,
  input  logic [DVD_W-1:0]       dividend,
  input  logic [DVS_W-1:0]       divisor,
  output logic                   done,
  output logic [DVD_W-1:0]       quotient
);
  import fwd_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W:0]   trial;
  logic             qbit;
  logic [DVS_W:0]   diff;

  always_comb begin
    trial = {rem_r, quo_r[DVD_W-1]};
    diff  = trial - {1'b0, dvs_r};
    qbit  = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl_in.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], qbit};
    end
  end

  assign quotient = quo_r;

endmodule

>>> rtl/frame_window_difference.sv
// Top level of the frame window difference block.
//
// Input channel: one beat per pixel pair (previous and next frame, B/G/R each)
// in raster order. Output channel: one beat per frame carrying the total of
// the per-pixel window ratios, 8 fraction bits, after the frame's last pixel.
// Pixel differences live in a ring of 2*MAX_HALF+1 rows in one RAM; column
// sums over a target row's window rows go to a second RAM, one word per column.
// Throughput: one pixel a cycle within a row. At the end of a row whose
// target row (h rows up) is complete the block stops taking beats while it
// processes that target row: the diff RAM read port does the column sums,
// the restoring divider sets the per-pixel rate.
// At the last row every outstanding target row is processed, then the total
// is loaded into the output register; it waits there while the receiver
// stalls, and the next frame's pixels are taken meanwhile.
// Reset (synchronous, rst_n low) restores 640x480, window side 5, and clears
// position and total; RAM contents are not cleared, since no entry is read
// before the current frame has written it. A register write restarts the frame.
module frame_window_difference #(
  parameter int MAX_WIDTH  = fwd_pkg::MAX_WIDTH_D,
  parameter int MAX_HEIGHT = fwd_pkg::MAX_HEIGHT_D,
  parameter int MAX_HALF   = fwd_pkg::MAX_HALF_D,
  parameter int FRAC_BITS  = fwd_pkg::FRAC_BITS_D
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fwd_pkg::PIX_W-1:0]     in_prev_b,
  input  logic [fwd_pkg::PIX_W-1:0]     in_prev_g,
  input  logic [fwd_pkg::PIX_W-1:0]     in_prev_r,
  input  logic [fwd_pkg::PIX_W-1:0]     in_next_b,
  input  logic [fwd_pkg::PIX_W-1:0]     in_next_g,
  input  logic [fwd_pkg::PIX_W-1:0]     in_next_r,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fwd_pkg::TOTAL_W-1:0]   out_frame_diff_total,
  input  logic                          cfg_we,
  input  logic [fwd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fwd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import fwd_pkg::*;

  localparam int RING     = 2 * MAX_HALF + 1;
  localparam int RING_W   = $clog2(RING);
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int WD_W     = $clog2(MAX_WIDTH + 1);
  localparam int HT_W     = $clog2(MAX_HEIGHT + 1);
  localparam int HALF_W   = $clog2(MAX_HALF + 1);
  localparam int CS_W     = $clog2(RING * DIFF_MAX + 1) + 1;
  localparam int WS_W     = $clog2(RING * RING * DIFF_MAX + 1) + 1;
  localparam int MAG_W    = WS_W - 1;
  localparam int DVD_W    = MAG_W + FRAC_BITS;
  localparam int SPAN_W   = $clog2(RING + 1);
  localparam int AREA_W   = 2 * SPAN_W;
  localparam int D_DEPTH  = RING * MAX_WIDTH;
  localparam int DA_W     = $clog2(D_DEPTH);

  // configuration
  logic [DIM_CFG_W-1:0]  frame_width_r, frame_height_r;
  logic [SIDE_CFG_W-1:0] window_side_r;
  logic                  cfg_hit;

  always_comb begin
    case (cfg_idx_t'(cfg_index))
      CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_WINDOW_SIDE: cfg_hit = cfg_we;
      default:                                            cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RST;
      frame_height_r <= HEIGHT_RST;
      window_side_r  <= SIDE_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[DIM_CFG_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[DIM_CFG_W-1:0];
        CFG_WINDOW_SIDE:  window_side_r  <= cfg_wdata[SIDE_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry: zero is one, oversize saturates
  logic [WD_W-1:0]       w_eff;
  logic [HT_W-1:0]       ht_eff;
  logic [HALF_W-1:0]     h;
  logic [SIDE_CFG_W-1:0] side_half;
  logic [COL_W-1:0]      w_last;
  logic [ROW_W-1:0]      ht_last;

  always_comb begin
    if (frame_width_r == '0)                              w_eff = WD_W'(1);
    else if (32'(frame_width_r) > 32'(MAX_WIDTH))         w_eff = WD_W'(MAX_WIDTH);
    else                                                  w_eff = WD_W'(frame_width_r);
    if (frame_height_r == '0)                             ht_eff = HT_W'(1);
    else if (32'(frame_height_r) > 32'(MAX_HEIGHT))       ht_eff = HT_W'(MAX_HEIGHT);
    else                                                  ht_eff = HT_W'(frame_height_r);
    side_half = window_side_r >> 1;
    if (32'(side_half) > 32'(MAX_HALF)) h = HALF_W'(MAX_HALF);
    else                                h = HALF_W'(side_half);
    w_last  = COL_W'(w_eff - 1'b1);
    ht_last = ROW_W'(ht_eff - 1'b1);
  end

  // sequencer
  fwd_state_t state_r, state_nxt;
  div_ctl_t   div_ctl;
  logic       in_fire, row_end, last_row, ge_h, out_free;

  logic [COL_W-1:0]  col_pos_r, ca_r, cb_r, cc_r, pa_col_r;
  logic [ROW_W-1:0]  row_pos_r, cur_r_r, t_r, t_end_r, rlo_r, rhi_r, xa_r;
  logic [RING_W-1:0] ring_pos_r, ring_cur_r, ring_lo_r, ringx_r;
  logic [SPAN_W-1:0] nrows_r;
  logic              last_frame_r;
  logic [TOTAL_W-1:0] total_r;
  logic              out_valid_r;
  logic [TOTAL_W-1:0] out_total_r;

  assign in_fire  = in_valid && in_ready;
  assign row_end  = (col_pos_r == w_last);
  assign last_row = (row_pos_r == ht_last);
  assign ge_h     = (row_pos_r >= ROW_W'(h));
  assign out_free = !out_valid_r || out_ready;

  // target row bounds
  logic [ROW_W-1:0]  rlo_c, rhi_c;
  logic [ROW_W:0]    tplus;
  logic [SPAN_W-1:0] nrows_c;
  logic [RING_W-1:0] dist_c, ring_lo_c;
  logic [RING_W:0]   ring_tmp;

  always_comb begin
    rlo_c    = (t_r >= ROW_W'(h)) ? t_r - ROW_W'(h) : '0;
    tplus    = {1'b0, t_r} + (ROW_W + 1)'(h);
    rhi_c    = (tplus > {1'b0, ht_last}) ? ht_last : tplus[ROW_W-1:0];
    nrows_c  = SPAN_W'(rhi_c - rlo_c + 1'b1);
    dist_c   = RING_W'(cur_r_r - rlo_c);
    ring_tmp = (RING_W + 1)'(ring_cur_r) + (RING_W + 1)'(RING) - (RING_W + 1)'(dist_c);
    if (ring_tmp >= (RING_W + 1)'(RING)) ring_tmp = ring_tmp - (RING_W + 1)'(RING);
    ring_lo_c = ring_tmp[RING_W-1:0];
  end

  // column bounds of the pixel being finished
  logic [COL_W-1:0]  clo_c, chi_c;
  logic [COL_W:0]    cplus;
  logic [SPAN_W-1:0] ncols_c;
  logic [AREA_W-1:0] area_c;

  always_comb begin
    clo_c   = (cb_r >= COL_W'(h)) ? cb_r - COL_W'(h) : '0;
    cplus   = {1'b0, cb_r} + (COL_W + 1)'(h);
    chi_c   = (cplus > {1'b0, w_last}) ? w_last : cplus[COL_W-1:0];
    ncols_c = SPAN_W'(chi_c - clo_c + 1'b1);
    area_c  = AREA_W'(nrows_r * ncols_c);
  end

  // RAMs
  logic [PIX_W+1:0]          prev_sum, next_sum;
  logic [DIFF_W-1:0]         pix_diff;
  logic [DA_W-1:0]           d_waddr, d_raddr;
  logic [DIFF_W-1:0]         d_rdata;
  logic signed [DIFF_W-1:0]  d_rdata_s;
  logic                      cs_we;
  logic [CS_W-1:0]           cs_rdata;
  logic signed [CS_W-1:0]    cs_rdata_s, psum, aacc_r;
  logic signed [WS_W-1:0]    wsum, wacc_r;
  logic                      pa_v_r, pa_first_r, pa_last_r;
  logic                      pb_v_r, pb_first_r;

  assign prev_sum = (PIX_W + 2)'(in_prev_b) + (PIX_W + 2)'(in_prev_g) + (PIX_W + 2)'(in_prev_r);
  assign next_sum = (PIX_W + 2)'(in_next_b) + (PIX_W + 2)'(in_next_g) + (PIX_W + 2)'(in_next_r);
  assign pix_diff = DIFF_W'({1'b0, next_sum}) - DIFF_W'({1'b0, prev_sum});
  assign d_waddr  = DA_W'(ring_pos_r) * DA_W'(MAX_WIDTH) + DA_W'(col_pos_r);
  assign d_raddr  = DA_W'(ringx_r) * DA_W'(MAX_WIDTH) + DA_W'(ca_r);

  fwd_ram #(.WIDTH(DIFF_W), .DEPTH(D_DEPTH)) u_diff_ram (
    .clk   (clk),
    .we    (in_fire),
    .waddr (d_waddr),
    .wdata (pix_diff),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  assign d_rdata_s  = d_rdata;
  assign psum       = (pa_first_r ? CS_W'(0) : aacc_r) + CS_W'(d_rdata_s);
  assign cs_we      = pa_v_r && pa_last_r;

  fwd_ram #(.WIDTH(CS_W), .DEPTH(MAX_WIDTH)) u_colsum_ram (
    .clk   (clk),
    .we    (cs_we),
    .waddr (pa_col_r),
    .wdata (psum),
    .raddr (cc_r),
    .rdata (cs_rdata)
  );

  assign cs_rdata_s = cs_rdata;
  assign wsum       = (pb_first_r ? WS_W'(0) : wacc_r) + WS_W'(cs_rdata_s);

  // divider
  logic [MAG_W-1:0] mag;
  logic [DVD_W-1:0] dividend, div_quo;
  logic             div_done;

  assign mag      = wsum[WS_W-1] ? MAG_W'(-wsum) : MAG_W'(wsum);
  assign dividend = DVD_W'(mag) << FRAC_BITS;

  fwd_div #(.DVD_W(DVD_W), .DVS_W(AREA_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (div_ctl),
    .dividend (dividend),
    .divisor  (area_c),
    .done     (div_done),
    .quotient (div_quo)
  );

  // next state
  always_comb begin
    state_nxt     = state_r;
    div_ctl.start = 1'b0;
    div_ctl.done  = div_done;
    in_ready      = (state_r == S_IDLE);
    case (state_r)
      S_IDLE:     if (in_fire && row_end && (ge_h || last_row)) state_nxt = S_TGT;
      S_TGT:      state_nxt = S_COL_RD;
      S_COL_RD:   if (xa_r == rhi_r && ca_r == w_last) state_nxt = S_COL_WAIT;
      S_COL_WAIT: state_nxt = S_WIN_SET;
      S_WIN_SET:  state_nxt = S_WIN_RD;
      S_WIN_RD:   if (cc_r == chi_c) state_nxt = S_WIN_WAIT;
      S_WIN_WAIT: begin
        div_ctl.start = !cfg_hit;
        state_nxt     = S_DIV;
      end
      S_DIV:      if (div_done) state_nxt = (cb_r == w_last) ? S_NEXT : S_WIN_SET;
      S_NEXT: begin
        if (t_r != t_end_r) state_nxt = S_TGT;
        else                state_nxt = last_frame_r ? S_OUT : S_IDLE;
      end
      S_OUT:      if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
    if (cfg_hit) state_nxt = S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // positions, total and pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r  <= '0;
      row_pos_r  <= '0;
      ring_pos_r <= '0;
      total_r    <= '0;
      pa_v_r     <= 1'b0;
      pb_v_r     <= 1'b0;
    end else begin
      pa_v_r <= (state_r == S_COL_RD) && !cfg_hit;
      pb_v_r <= (state_r == S_WIN_RD) && !cfg_hit;
      if (cfg_hit) begin
        col_pos_r  <= '0;
        row_pos_r  <= '0;
        ring_pos_r <= '0;
        total_r    <= '0;
      end else begin
        if (in_fire) begin
          if (!row_end) begin
            col_pos_r <= col_pos_r + 1'b1;
          end else begin
            col_pos_r <= '0;
            if (last_row) begin
              row_pos_r  <= '0;
              ring_pos_r <= '0;
            end else begin
              row_pos_r  <= row_pos_r + 1'b1;
              ring_pos_r <= (ring_pos_r == RING_W'(RING - 1)) ? '0 : ring_pos_r + 1'b1;
            end
          end
        end
        if (state_r == S_DIV && div_done) total_r <= total_r + TOTAL_W'(div_quo);
        if (state_r == S_OUT && out_free) total_r <= '0;
      end
    end
  end

  // sequencer payload
  always_ff @(posedge clk) begin
    if (in_fire && row_end) begin
      cur_r_r      <= row_pos_r;
      ring_cur_r   <= ring_pos_r;
      last_frame_r <= last_row;
      t_r          <= ge_h ? row_pos_r - ROW_W'(h) : '0;
      t_end_r      <= last_row ? row_pos_r : row_pos_r - ROW_W'(h);
    end
    case (state_r)
      S_TGT: begin
        rlo_r     <= rlo_c;
        rhi_r     <= rhi_c;
        nrows_r   <= nrows_c;
        ring_lo_r <= ring_lo_c;
        ca_r      <= '0;
        xa_r      <= rlo_c;
        ringx_r   <= ring_lo_c;
      end
      S_COL_RD: begin
        if (xa_r == rhi_r) begin
          xa_r    <= rlo_r;
          ringx_r <= ring_lo_r;
          ca_r    <= ca_r + 1'b1;
        end else begin
          xa_r    <= xa_r + 1'b1;
          ringx_r <= (ringx_r == RING_W'(RING - 1)) ? '0 : ringx_r + 1'b1;
        end
      end
      S_COL_WAIT: cb_r <= '0;
      S_WIN_SET:  cc_r <= clo_c;
      S_WIN_RD:   if (cc_r != chi_c) cc_r <= cc_r + 1'b1;
      S_DIV:      if (div_done && cb_r != w_last) cb_r <= cb_r + 1'b1;
      S_NEXT:     if (t_r != t_end_r) t_r <= t_r + 1'b1;
      default: ;
    endcase
    pa_first_r <= (xa_r == rlo_r);
    pa_last_r  <= (xa_r == rhi_r);
    pa_col_r   <= ca_r;
    pb_first_r <= (cc_r == clo_c);
    if (pa_v_r) aacc_r <= psum;
    if (pb_v_r) wacc_r <= wsum;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (state_r == S_OUT && out_free && !cfg_hit) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) out_total_r <= total_r;
  end

  assign out_valid            = out_valid_r;
  assign out_frame_diff_total = out_total_r;

  // checks
  a_cs_we_in_colpass: assert property (@(posedge clk) disable iff (!rst_n)
    cs_we |-> (state_r == S_COL_RD || state_r == S_COL_WAIT))
    else $error("column sum written outside column pass");

  a_idle_pipes_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!pa_v_r && !pb_v_r))
    else $error("beat taken while a read is in flight");

  a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside output state");

endmodule

>>> bench/fwd_checker.sv
// Scoreboard for frame_window_difference: models the block and checks each frame total.
`timescale 1ns / 1ps
module fwd_checker
  import fwd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [PIX_W-1:0]      in_prev_b,
  input  logic [PIX_W-1:0]      in_prev_g,
  input  logic [PIX_W-1:0]      in_prev_r,
  input  logic [PIX_W-1:0]      in_next_b,
  input  logic [PIX_W-1:0]      in_next_g,
  input  logic [PIX_W-1:0]      in_next_r,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [TOTAL_W-1:0]    out_frame_diff_total,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    errors,
  output int                    pending
);

  localparam int RING = 2 * MAX_HALF_D + 1;

  logic signed [DIFF_W-1:0] diff_ring [0:RING-1][0:MAX_WIDTH_D-1];
  logic [DIM_CFG_W-1:0]     width_reg;
  logic [DIM_CFG_W-1:0]     height_reg;
  logic [SIDE_CFG_W-1:0]    side_reg;
  logic [TOTAL_W-1:0]       frame_sum;
  int unsigned              row_pos;
  int unsigned              col_pos;
  logic [TOTAL_W-1:0]       expected_totals [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic int unsigned eff_dim(int unsigned v, int unsigned m);
    if (v == 0) return 1;
    return (v > m) ? m : v;
  endfunction

  // Add the window ratios of every pixel of row t to the running total.
  task automatic add_row_ratios(int unsigned t, int unsigned w, int unsigned ht,
                                int unsigned h);
    int unsigned       rlo;
    int unsigned       rhi;
    int unsigned       clo;
    int unsigned       chi;
    longint            col_acc [0:MAX_WIDTH_D];
    longint            s;
    longint unsigned   mag;
    longint unsigned   area;
    rlo = (t >= h) ? t - h : 0;
    rhi = (t + h < ht - 1) ? t + h : ht - 1;
    col_acc[0] = 0;
    for (int unsigned c = 0; c < w; c++) begin
      s = 0;
      for (int unsigned r = rlo; r <= rhi; r++) s += longint'(diff_ring[r % RING][c]);
      col_acc[c + 1] = col_acc[c] + s;
    end
    for (int unsigned c = 0; c < w; c++) begin
      clo  = (c >= h) ? c - h : 0;
      chi  = (c + h < w - 1) ? c + h : w - 1;
      area = longint'(rhi - rlo + 1) * longint'(chi - clo + 1);
      s    = col_acc[chi + 1] - col_acc[clo];
      mag  = (s < 0) ? -s : s;
      frame_sum = frame_sum + TOTAL_W'((mag << FRAC_BITS_D) / area);
    end
  endtask

  task automatic take_pixel();
    int unsigned w;
    int unsigned ht;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    int          d;
    w  = eff_dim(width_reg, MAX_WIDTH_D);
    ht = eff_dim(height_reg, MAX_HEIGHT_D);
    h  = side_reg / 2;
    if (h > MAX_HALF_D) h = MAX_HALF_D;
    r = (row_pos >= ht) ? ht - 1 : row_pos;
    c = (col_pos >= w) ? w - 1 : col_pos;
    d = int'(in_next_b) + int'(in_next_g) + int'(in_next_r)
      - int'(in_prev_b) - int'(in_prev_g) - int'(in_prev_r);
    diff_ring[r % RING][c] = DIFF_W'(d);
    if (c + 1 < w) begin
      col_pos = c + 1;
      row_pos = r;
    end else begin
      if (r >= h) add_row_ratios(r - h, w, ht, h);
      if (r + 1 >= ht) begin
        // bottom rows: their windows are complete only now
        for (int unsigned t = (r >= h) ? r - h + 1 : 0; t <= r; t++)
          add_row_ratios(t, w, ht, h);
        expected_totals.push_back(frame_sum);
        frame_sum = '0;
        row_pos   = 0;
      end else begin
        row_pos = r + 1;
      end
      col_pos = 0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      side_reg   = SIDE_RST;
      frame_sum  = '0;
      row_pos    = 0;
      col_pos    = 0;
      expected_totals.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_FRAME_WIDTH:  width_reg  = cfg_wdata[DIM_CFG_W-1:0];
          CFG_FRAME_HEIGHT: height_reg = cfg_wdata[DIM_CFG_W-1:0];
          CFG_WINDOW_SIDE:  side_reg   = cfg_wdata[SIDE_CFG_W-1:0];
          default: ;
        endcase
        // only a write to a real register restarts the frame
        if (cfg_idx_t'(cfg_index) inside {CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT,
                                          CFG_WINDOW_SIDE}) begin
          frame_sum = '0;
          row_pos   = 0;
          col_pos   = 0;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_totals.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected total %0d", out_frame_diff_total);
        end else begin
          if (out_frame_diff_total !== expected_totals[0]) begin
            errors++;
            if (errors <= 10)
              $display("total mismatch: expected %0d got %0d",
                       expected_totals[0], out_frame_diff_total);
          end
          void'(expected_totals.pop_front());
        end
      end
      if (in_valid && in_ready) take_pixel();
    end
    pending = expected_totals.size();
  end

endmodule

>>> bench/frame_window_difference_test.sv
// Top of the frame_window_difference bench: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
module frame_window_difference_test;
  import fwd_pkg::*;

  // pixel pattern of a frame
  typedef enum int {PAT_RANDOM, PAT_BRIGHTEN, PAT_DARKEN, PAT_STILL} pattern_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      in_prev_b = '0;
  logic [PIX_W-1:0]      in_prev_g = '0;
  logic [PIX_W-1:0]      in_prev_r = '0;
  logic [PIX_W-1:0]      in_next_b = '0;
  logic [PIX_W-1:0]      in_next_g = '0;
  logic [PIX_W-1:0]      in_next_r = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [TOTAL_W-1:0]    out_frame_diff_total;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int errors;
  int pending;
  int pixels_sent = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  // cycles the block may still be busy on a target row with small frames
  localparam int SETTLE_CYCLES = 3000;

  frame_window_difference u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_prev_b(in_prev_b), .in_prev_g(in_prev_g), .in_prev_r(in_prev_r),
    .in_next_b(in_next_b), .in_next_g(in_next_g), .in_next_r(in_next_r),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_frame_diff_total(out_frame_diff_total),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  fwd_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_prev_b(in_prev_b), .in_prev_g(in_prev_g), .in_prev_r(in_prev_r),
    .in_next_b(in_next_b), .in_next_g(in_next_g), .in_next_r(in_next_r),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_frame_diff_total(out_frame_diff_total),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  always #10 clk = ~clk;

  // No idling on either side while this is true.
  function automatic bit calm_stretch();
    return pixels_sent >= 300 && pixels_sent < 420;
  endfunction

  // Receiver: random stalls, plus one long hold-off so the block backs up onto the input.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!hold_done && hold_req) begin
        hold_done = 1'b1;
        hold_left = 4000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm_stretch() || $urandom_range(99) >= 20;
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Registers change only when the block has drained; the last beat is withdrawn first.
  task automatic wait_idle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] pb, logic [PIX_W-1:0] pg, logic [PIX_W-1:0] pr,
                            logic [PIX_W-1:0] nb, logic [PIX_W-1:0] ng, logic [PIX_W-1:0] nr);
    while (!calm_stretch() && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_prev_b <= pb;
    in_prev_g <= pg;
    in_prev_r <= pr;
    in_next_b <= nb;
    in_next_g <= ng;
    in_next_r <= nr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
  endtask

  function automatic logic [PIX_W-1:0] rand_pix();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  task automatic send_pattern(pattern_t pat);
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] hi;
    lo = '0;
    hi = '1;
    case (pat)
      PAT_BRIGHTEN: send_pixel(lo, lo, lo, hi, hi, hi);
      PAT_DARKEN:   send_pixel(hi, hi, hi, lo, lo, lo);
      PAT_STILL: begin
        lo = rand_pix();
        hi = rand_pix();
        send_pixel(lo, hi, lo, lo, hi, lo);
      end
      default: send_pixel(rand_pix(), rand_pix(), rand_pix(),
                          rand_pix(), rand_pix(), rand_pix());
    endcase
  endtask

  // Set up a frame geometry and stream one whole frame through.
  task automatic run_frame(int unsigned w, int unsigned ht, int unsigned side,
                           int unsigned pixels, pattern_t pat);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, ht);
    write_reg(CFG_WINDOW_SIDE, side);
    for (int unsigned i = 0; i < pixels; i++) send_pattern(pat);
  endtask

  initial begin
    int unsigned w;
    int unsigned ht;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero dimensions act as one, single-pixel window, full swings both ways
    run_frame(0, 0, 0, 1, PAT_BRIGHTEN);
    run_frame(1, 1, 1, 1, PAT_DARKEN);
    run_frame(3, 3, 15, 9, PAT_BRIGHTEN);
    run_frame(4, 2, 2, 8, PAT_STILL);
    run_frame(2, 3, 3, 6, PAT_DARKEN);
    // a write mid-frame throws the partial frame away
    run_frame(4, 4, 5, 5, PAT_RANDOM);
    for (int i = 0; i < 16; i++) send_pattern(PAT_RANDOM);
    in_valid <= 1'b0;
    @(posedge clk);
    wait_idle();
    write_reg(CFG_WINDOW_SIDE, 4);
    for (int i = 0; i < 16; i++) send_pattern(PAT_RANDOM);
    // oversized registers saturate to the maximum frame size; partial frames only
    run_frame(2047, 1, 15, 64, PAT_RANDOM);
    run_frame(1, 2047, 14, 64, PAT_DARKEN);
    // receiver holds off over a run of small frames, so the input backs up
    wait_idle();
    hold_req = 1'b1;
    run_frame(2, 2, 3, 32, PAT_RANDOM);

    // random frames, mostly small, sometimes several under one geometry
    while (pixels_sent < 500) begin
      w  = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(8, 1);
      ht = $urandom_range(8, 1);
      if ($urandom_range(9) == 0) begin
        // broken frame: abandoned part way by the next register write
        run_frame(w, ht, $urandom_range(15), $urandom_range(w * ht), PAT_RANDOM);
        in_valid <= 1'b0;
        @(posedge clk);
      end else begin
        run_frame(w, ht, $urandom_range(15), w * ht * $urandom_range(3, 1),
                  ($urandom_range(9) == 0) ? pattern_t'($urandom_range(3)) : PAT_RANDOM);
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #80ms;
    $display("simulation failed");
    $finish;
  end

endmodule
